// ===== src/stbs_pkg.sv =====
package stbs_pkg;

  // Table geometry.
  localparam int unsigned TBL_DEPTH = 1024;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  // Bounds and sizes must hold the depth itself.
  localparam int unsigned CNT_W     = TBL_AW + 1;

  // Field widths.
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned SIZE_W    = 11;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SEARCH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROBE = 2'd1,
    ST_MISS  = 2'd2
  } state_e;

endpackage

// ===== src/stbs_ram.sv =====
module stbs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/sorted_table_binary_search_unit.sv =====
// Channel   | Direction | Transaction contents
// ----------+-----------+------------------------------------------------------
// s_axis    | in        | tuser: action; tdata: load_index, element_value,
//           |           |   search_key
// m_axis    | out       | tuser: found; tdata: found_index
// cfg       | in        | cfg_we_i / cfg_wdata_i write active_size
//
// A load transaction writes one table entry in the cycle it is accepted and
// gives no result; the input is ready again in the next cycle.
// A search transaction issues the first table read in the cycle it is accepted
// and then makes one probe per cycle, since the compare of a read value and the
// computation of the next midpoint share the single read port: at most
// log2(depth)+1 probes.
// The result sits in an output register, so a new transaction is accepted while
// an earlier result waits; a finished search holds its last probe while the
// output register is full.
// Reset clears the control state and active_size; the table is not cleared.
module sorted_table_binary_search_unit
  import stbs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_wdata_i,    // active_size

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [9:0] load_index, [41:10] element_value, [73:42] search_key, [79:74] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,   // [0] action

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] found_index, [15:10] zero
  output logic                   m_axis_tuser    // [0] found
);

  // Input field extraction.
  logic [IDX_W-1:0] in_load_index;
  logic [VAL_W-1:0] in_value;
  logic [VAL_W-1:0] in_key;
  action_e          in_action;

  assign in_load_index = s_axis_tdata[IDX_W-1:0];
  assign in_value      = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_key        = s_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
  assign in_action     = action_e'(s_axis_tuser);

  // Configuration register.
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Search range is clamped to the table depth.
  logic [CNT_W-1:0] size_clamped;
  assign size_clamped = (32'(size_q) > TBL_DEPTH) ? CNT_W'(TBL_DEPTH) : CNT_W'(size_q);

  // Control and search state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] low_q, low_d;     // first index still in range
  logic [CNT_W-1:0] end_q, end_d;     // one past the last index still in range
  logic [CNT_W-1:0] mid_q, mid_d;     // index whose read is in flight
  logic [VAL_W-1:0] key_q, key_d;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;

  // Table memory.
  logic             tbl_we;
  logic [VAL_W-1:0] tbl_rdata;

  logic             s_fire;
  logic             slot_free;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;

  // Loads and searches are only accepted in idle, so a write and a read of the
  // table never overlap; a search right after a load sees the new entry.
  assign tbl_we = s_fire && (in_action == ACT_LOAD) && (32'(in_load_index) < TBL_DEPTH);

  stbs_ram #(
    .DEPTH (TBL_DEPTH),
    .WIDTH (VAL_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_load_index[TBL_AW-1:0]),
    .wdata_i (in_value),
    .raddr_i (mid_d[TBL_AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Probe comparison and next bounds.
  logic             probe_eq;
  logic             probe_lt;
  logic [CNT_W-1:0] next_low;
  logic [CNT_W-1:0] next_end;
  logic [CNT_W-1:0] bnd_low;
  logic [CNT_W-1:0] bnd_end;
  logic [CNT_W-1:0] mid_calc;

  assign probe_eq = (tbl_rdata == key_q);
  assign probe_lt = $signed(tbl_rdata) < $signed(key_q);
  assign next_low = probe_lt ? (mid_q + CNT_W'(1)) : low_q;
  assign next_end = probe_lt ? end_q : mid_q;

  // Midpoint of a nonempty range [low, end): low + floor((end - 1 - low) / 2).
  assign bnd_low  = (state_q == ST_IDLE) ? '0 : next_low;
  assign bnd_end  = (state_q == ST_IDLE) ? size_clamped : next_end;
  assign mid_calc = bnd_low + ((bnd_end - bnd_low - CNT_W'(1)) >> 1);

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    end_d       = end_q;
    mid_d       = mid_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (s_fire && (in_action == ACT_SEARCH)) begin
          key_d = in_key;
          if (size_clamped == '0) begin
            state_d = ST_MISS;
          end else begin
            low_d   = '0;
            end_d   = size_clamped;
            mid_d   = mid_calc;
            state_d = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        // Read data for mid_q is valid here. When the result cannot be
        // written yet, mid_q is read again so the data stays valid.
        if (probe_eq) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_found_d = 1'b1;
            out_idx_d   = IDX_W'(mid_q);
            state_d     = ST_IDLE;
          end
        end else if (next_low < next_end) begin
          low_d = next_low;
          end_d = next_end;
          mid_d = mid_calc;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_idx_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_idx_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      low_q       <= '0;
      end_q       <= '0;
      mid_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      low_q       <= low_d;
      end_q       <= end_d;
      mid_q       <= mid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    out_found_q <= out_found_d;
    out_idx_q <= out_idx_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_idx_q);

  // While probing, the range is nonempty and the probed index lies inside it.
  a_range_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (low_q < end_q))
    else $error("search range empty while probing");

  a_mid_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> ((mid_q >= low_q) && (mid_q < end_q)))
    else $error("probe index outside search range");

  a_end_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (32'(end_q) <= TBL_DEPTH))
    else $error("search range exceeds table depth");

  a_search_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (in_action == ACT_SEARCH)) |=> ((state_q == ST_PROBE) || (state_q == ST_MISS)))
    else $error("accepted search did not start");

  a_miss_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-found result carries a nonzero index");

endmodule

// ===== dv/tb_sorted_table_binary_search_unit.sv =====
module tb_sorted_table_binary_search_unit
  import stbs_pkg::*;
();

  localparam int ITEM_TARGET = 1550;
  localparam int HOLD_CYCLES = 200;
  // Long enough to cover the slowest search.
  localparam int IDLE_TAIL   = 16;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    action_e          act;
    logic [IDX_W-1:0] load_idx;
    logic [VAL_W-1:0] elem;
    logic [VAL_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } lookup_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  sorted_table_binary_search_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the table and the size register as the block sees them.
  logic signed [VAL_W-1:0] value_tbl [TBL_DEPTH];
  logic [SIZE_W-1:0]       size_reg = '0;

  // Stimulus side: what the generator has planned to load so far.
  logic [VAL_W-1:0] plan_tbl [TBL_DEPTH];
  int               search_span = 0;
  int               item_cnt    = 0;

  request_t request_q [$];
  lookup_t  lookup_q [$];

  int   err_cnt   = 0;
  int   cycle_cnt = 0;
  bit   in_taken  = 1'b0;
  bit   out_taken = 1'b0;
  int   in_gap    = 0;
  int   out_gap   = 0;
  bit   in_calm   = 1'b0;
  bit   out_calm  = 1'b0;
  bit   hold_req  = 1'b0;
  int   hold_left = 0;

  // Binary search over the first size_reg entries, clamped to the table depth.
  function automatic lookup_t search_table(input logic signed [VAL_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    lookup_t res;
    res.found = 1'b0;
    res.index = '0;
    lo = 0;
    hi = ((size_reg > TBL_DEPTH) ? int'(TBL_DEPTH) : int'(size_reg)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (value_tbl[mid[TBL_AW-1:0]] == key) begin
        res.found = 1'b1;
        res.index = mid[IDX_W-1:0];
        return res;
      end
      if (value_tbl[mid[TBL_AW-1:0]] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  // Monitor. The output side is checked before the input side is predicted, so a
  // search accepted in this cycle can never be matched against an early result.
  always @(posedge clk_i) begin
    lookup_t want;
    in_taken  = s_axis_tvalid && s_axis_tready;
    out_taken = m_axis_tvalid && m_axis_tready;
    if (out_taken) begin
      if (lookup_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result without a pending search: found %0b found_index %0d",
                 $time, m_axis_tuser, m_axis_tdata[IDX_W-1:0]);
      end else begin
        want = lookup_q.pop_front();
        if (m_axis_tuser !== want.found) begin
          err_cnt++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, m_axis_tuser);
        end
        if (m_axis_tdata[IDX_W-1:0] !== want.index) begin
          err_cnt++;
          $display("%0t: found_index expected %0d actual %0d",
                   $time, want.index, m_axis_tdata[IDX_W-1:0]);
        end
      end
    end
    if (in_taken) begin
      if (s_axis_tuser == ACT_LOAD) begin
        value_tbl[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
      end else begin
        lookup_q.push_back(search_table($signed(s_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W])));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sender: a transaction stays offered until taken, then a randomly drawn gap,
  // which may be empty, goes ahead of the next one. Calm stretches send back to back.
  always @(negedge clk_i) begin
    request_t req;
    if (!s_axis_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        req = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.act;
        s_axis_tdata  <= {{(IN_TDATA_W-IDX_W-2*VAL_W){1'b0}}, req.key, req.elem, req.load_idx};
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a random stall, which may be empty, after each result, and one long
  // hold-off on request so that the output register fills and the input backs up.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (out_taken) begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      out_gap = out_calm ? 0 : $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    request_t req;
    req.act      = ACT_LOAD;
    req.load_idx = idx;
    req.elem     = val;
    req.key      = $urandom;
    plan_tbl[idx] = val;
    request_q.push_back(req);
    item_cnt++;
  endtask

  task automatic queue_search(input logic [VAL_W-1:0] key);
    request_t req;
    req.act      = ACT_SEARCH;
    req.load_idx = IDX_W'($urandom);
    req.elem     = $urandom;
    req.key      = key;
    request_q.push_back(req);
    item_cnt++;
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || s_axis_tvalid || lookup_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  // The size register is only written while nothing is in flight.
  task automatic set_size(input logic [SIZE_W-1:0] sz);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg    = sz;
    search_span = (sz > TBL_DEPTH) ? int'(TBL_DEPTH) : int'(sz);
    @(posedge clk_i);
  endtask

  // Loads entries 0..n-1 in ascending order; a zero step gives duplicates.
  task automatic fill_sorted(input int n, input longint start, input int step_max);
    longint acc;
    int     k;
    acc = start;
    for (k = 0; k < n; k++) begin
      queue_load(IDX_W'(k), acc[VAL_W-1:0]);
      acc += longint'($urandom_range(0, step_max));
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    end
  endtask

  // Mostly keys that exist in the searched range, some off by one, some random.
  function automatic logic [VAL_W-1:0] pick_key();
    int idx;
    if (search_span == 0) return $urandom;
    idx = $urandom_range(0, search_span - 1);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2, 3:    return plan_tbl[idx[TBL_AW-1:0]] + 1;
      4:       return plan_tbl[idx[TBL_AW-1:0]] - 1;
      default: return plan_tbl[idx[TBL_AW-1:0]];
    endcase
  endfunction

  // Searches with a little noise: stray loads anywhere, and loads that break the
  // ordering of the searched range.
  task automatic search_burst(input int count);
    int k;
    int r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        queue_load(IDX_W'($urandom_range(0, TBL_DEPTH - 1)), $urandom);
      end else if (r == 1 && search_span > 0) begin
        queue_load(IDX_W'($urandom_range(0, search_span - 1)), $urandom);
      end else begin
        queue_search(pick_key());
      end
    end
  endtask

  initial begin
    int sz;
    int base;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. An empty range must miss without touching the table.
    set_size(0);
    queue_search(32'h0000_0000);
    queue_load(0, 32'h8000_0000);
    queue_load(1, 32'hffff_ffff);
    queue_load(2, 32'h0000_0000);
    queue_load(3, 32'h0000_0001);
    queue_load(4, 32'h7fff_ffff);
    set_size(5);
    queue_search(32'h8000_0000);
    queue_search(32'hffff_ffff);
    queue_search(32'h0000_0000);
    queue_search(32'h0000_0001);
    queue_search(32'h7fff_ffff);
    queue_search(32'hffff_fffe);
    queue_search(32'h0000_0002);
    queue_search(32'h7fff_fffe);
    // An unsorted table: the middle entry now holds the maximum, so zero is
    // no longer reachable while the maximum is found at once.
    queue_load(2, 32'h7fff_ffff);
    queue_search(32'h0000_0000);
    queue_search(32'h7fff_ffff);
    set_size(1);
    queue_search(32'h8000_0000);
    queue_search(32'h0000_0005);

    // Full table, sorted over the whole signed range.
    set_size(SIZE_W'(TBL_DEPTH));
    fill_sorted(TBL_DEPTH, -64'sd2147483648, 4194304);
    queue_load(IDX_W'(TBL_DEPTH - 1), 32'h7fff_ffff);
    while (request_q.size() != 0) @(posedge clk_i);
    hold_req = 1'b1;
    search_burst(80);

    // A size beyond the table depth searches the whole table.
    set_size({SIZE_W{1'b1}});
    search_burst(40);

    // Mostly small sorted ranges, with some resizes over what is already loaded.
    while (item_cnt < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: set_size(0);
        1: set_size(SIZE_W'(TBL_DEPTH));
        2: set_size(SIZE_W'($urandom_range(1, TBL_DEPTH)));
        default: begin
          sz   = $urandom_range(1, 40);
          base = $urandom;
          set_size(SIZE_W'(sz));
          fill_sorted(sz, longint'(base), 1 << $urandom_range(0, 26));
        end
      endcase
      search_burst($urandom_range(10, 30));
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
